[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked property, masked while reset is high
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// clocked property, checked during reset as well
`define ASSERT_PROP_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_PROP_NR(label, clk, prop, msg)
`endif

`endif

[rtl/strs_pkg.sv]
// ----------------------------------------------------------------------------
// strs_pkg
// shared types and field widths of the segment tree range sum core
// ----------------------------------------------------------------------------
`default_nettype none

package strs_pkg;

   localparam int CMD_W = 2;
   localparam int IDX_W = 10;
   localparam int VAL_W = 32;
   localparam int SUM_W = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET   = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      S_CLR,
      S_IDLE,
      S_UP,
      S_QA,
      S_QB,
      S_LEAF,
      S_OUT
   } state_type;

endpackage

`default_nettype wire

[rtl/strs_ram.sv]
// ----------------------------------------------------------------------------
// strs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module strs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/segment_tree_range_sum_core.sv]
// ----------------------------------------------------------------------------
// segment_tree_range_sum_core
// point update and range sum over a bottom-up segment tree of 64-bit sums
// ----------------------------------------------------------------------------
// The core keeps 2*LEAVES node sums in one ram with one write and one
// registered read port; leaf i sits at node LEAVES+i and node k holds the sum
// of nodes 2k and 2k+1. After reset a clearing pass writes zero to every node,
// one per cycle, and req_stall stays high meanwhile. One item is worked at a
// time and req_stall is high until it is finished. A set writes the leaf,
// then walks up through its D ancestors, with D the tree depth (10 at
// LEAVES=1024), each step reading the sibling and adding it in the one
// 64-bit adder. A query walks both range edges up the tree level by level,
// alternating S_QA and S_QB, as both edges share the one read port.
// A read fetches the leaf through S_LEAF. An empty range or an out of range
// index skips the walk. A set and command code 3 give no result transfer. The
// result sits in an output register, so the core finishes an item while an
// earlier result still waits on rsp_stall; it holds back only when a second
// result is ready. All sums wrap in 64-bit two's complement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module segment_tree_range_sum_core #(
   parameter int LEAVES = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic        [strs_pkg::CMD_W-1:0]   req_command,
   input  wire logic        [strs_pkg::IDX_W-1:0]   req_first_index,
   input  wire logic        [strs_pkg::IDX_W-1:0]   req_last_index,
   input  wire logic signed [strs_pkg::VAL_W-1:0]   req_new_value,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [strs_pkg::SUM_W-1:0]   rsp_total
);

   import strs_pkg::*;

   localparam int NODES = 2 * LEAVES;
   localparam int AW    = $clog2(NODES);

   // sequencer state
   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             pend_a_ff, pend_a_in;   // node a read last cycle is to be added
   logic             pend_b_ff, pend_b_in;   // node b read last cycle is to be added
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [SUM_W-1:0]        acc_ff, acc_in;
   logic [AW-1:0]           a_ff, a_in;      // node walked upward, left edge for query
   logic [AW-1:0]           b_ff, b_in;      // right edge for query
   logic signed [SUM_W-1:0] rsp_total_ff, rsp_total_in;

   // node ram
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [SUM_W-1:0] ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [SUM_W-1:0] ram_rdata;

   // shared adder
   logic             take;
   logic [SUM_W-1:0] sum;

   // request decode
   logic [31:0]   first32;
   logic [31:0]   last32;
   logic [31:0]   hi32;
   logic          idx_ok;
   logic          range_empty;
   logic [AW-1:0] leaf_addr;
   logic [AW-1:0] hi_addr;
   logic [AW-1:0] parent;
   logic          out_free;

   strs_ram #(
      .WIDTH (SUM_W),
      .DEPTH (NODES)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign first32     = 32'(req_first_index);
   assign last32      = 32'(req_last_index);
   // range end clips to the last leaf
   assign hi32        = (last32 >= 32'(LEAVES)) ? 32'(LEAVES - 1) : last32;
   assign idx_ok      = first32 < 32'(LEAVES);
   assign range_empty = first32 > hi32;
   assign leaf_addr   = AW'(req_first_index) + AW'(LEAVES);
   assign hi_addr     = AW'(hi32) + AW'(LEAVES);
   assign parent      = a_ff >> 1;

   assign sum = acc_ff + (take ? ram_rdata : '0);

   // a finished result may go out when the output register is empty or draining
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pend_a_in    = pend_a_ff;
      pend_b_in    = pend_b_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rsp_total_in = rsp_total_ff;
      // result register empties on a transfer
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_waddr    = a_ff;
      ram_wdata    = sum;
      ram_raddr    = a_ff;
      take         = 1'b0;

      unique case (state_ff)
         S_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               unique case (req_command)
                  CMD_SET: begin
                     // write the leaf and fetch its sibling in the same cycle
                     if (idx_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = leaf_addr;
                        ram_wdata = SUM_W'(req_new_value);
                        ram_raddr = leaf_addr ^ AW'(1);
                        acc_in    = SUM_W'(req_new_value);
                        a_in      = leaf_addr;
                        state_in  = S_UP;
                     end
                  end
                  CMD_QUERY: begin
                     acc_in    = '0;
                     pend_a_in = 1'b0;
                     pend_b_in = 1'b0;
                     a_in      = leaf_addr;
                     b_in      = hi_addr;
                     state_in  = range_empty ? S_OUT : S_QA;
                  end
                  CMD_READ: begin
                     acc_in    = '0;
                     ram_raddr = leaf_addr;
                     state_in  = idx_ok ? S_LEAF : S_OUT;
                  end
                  default: begin
                     // unused code, dropped
                  end
               endcase
            end
         end

         S_UP: begin
            // parent sum from running sum and sibling
            take      = 1'b1;
            ram_we    = 1'b1;
            ram_waddr = parent;
            ram_wdata = sum;
            acc_in    = sum;
            ram_raddr = parent ^ AW'(1);
            a_in      = parent;
            if (parent == AW'(1)) begin
               state_in = S_IDLE;
            end
         end

         S_QA: begin
            // add right edge node fetched last level, then test the loop
            take   = pend_b_ff;
            acc_in = sum;
            if (a_ff <= b_ff) begin
               ram_raddr = a_ff;
               pend_a_in = a_ff[0];
               state_in  = S_QB;
            end else begin
               state_in  = S_OUT;
            end
         end

         S_QB: begin
            // add left edge node, fetch right edge node, step up one level
            take      = pend_a_ff;
            acc_in    = sum;
            ram_raddr = b_ff;
            pend_b_in = !b_ff[0];
            a_in      = (a_ff >> 1) + AW'(a_ff[0]);
            b_in      = (b_ff >> 1) - AW'(!b_ff[0]);
            state_in  = S_QA;
         end

         S_LEAF: begin
            take     = 1'b1;
            acc_in   = sum;
            state_in = S_OUT;
         end

         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = acc_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         pend_a_ff    <= 1'b0;
         pend_b_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_a_ff    <= pend_a_in;
         pend_b_ff    <= pend_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_total = rsp_total_ff;

   // upward walk never reaches the root as a child
   `ASSERT_PROP(a_up_below_root, clock, reset, (state_ff == S_UP) |-> (a_ff > AW'(1)), "set walk passed the root")
   // left query edge stays inside the node store, right edge may drop to zero at the end
   `ASSERT_PROP(a_qa_in_tree, clock, reset, (state_ff == S_QA) |-> (a_ff >= AW'(1)), "query edge left the tree")
   // a finished result waits while the previous one is stalled
   `ASSERT_PROP(a_out_waits, clock, reset, (state_ff == S_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == S_OUT && rsp_valid_ff), "result dropped under stall")
   // clearing pass holds off requests and writes a node every cycle
   `ASSERT_PROP(a_clear_blocks, clock, reset, (state_ff == S_CLR) |-> (req_stall && ram_we), "clearing pass not exclusive")

endmodule

`default_nettype wire
